/* src/aoe_pkg.sv */
// shared types and constants for the aoe critical path block
// no dependencies
package aoe_pkg;

    localparam int MaxVertices = 64;
    localparam int MaxEdges    = 128;

    localparam logic [1:0] StatusOk      = 2'd0;
    localparam logic [1:0] StatusBadSrc  = 2'd1;
    localparam logic [1:0] StatusNotDag  = 2'd2;

    localparam logic CfgVertexCount = 1'b0;
    localparam logic CfgSourceVertex = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CLR, ST_DEG_A, ST_DEG_B, ST_DEG_C, ST_CHK_A, ST_CHK_B,
        ST_FPOP, ST_FV, ST_FE, ST_FA, ST_FB, ST_FC, ST_SCAN_A, ST_SCAN_B,
        ST_BPOP, ST_BV, ST_BE, ST_BA, ST_BB, ST_BC, ST_BW, ST_OUT_A, ST_OUT_B,
        ST_ERR
    } t_state;

    typedef enum logic [4:0] {
        C_LOAD, C_CLR, C_DEG_A, C_DEG_B, C_DEG_C, C_CHK_A, C_CHK_B,
        C_FPOP, C_FV, C_FE, C_FA, C_FB, C_FC, C_SCAN_A, C_SCAN_B,
        C_BPOP, C_BV, C_BE, C_BA, C_BB, C_BC, C_BW, C_OUT_A, C_OUT_B,
        C_ERR
    } t_cmd;

    typedef struct packed {
        logic last_beat;
        logic clr_last;
        logic k_end;
        logic match;
        logic src_bad;
        logic q_empty;
        logic i_end;
        logic deg_nz;
        logic top_zero;
        logic slot_free;
    } t_status;

endpackage

/* src/aoe_if.sv */
// handshake channels of the aoe critical path block: edges, results, config
// depends on nothing
interface aoe_edge_if;
    logic        valid;
    logic        ready;
    logic [5:0]  edge_from;
    logic [5:0]  edge_to;
    logic [15:0] edge_weight;
    logic        last_edge;
    modport source (output valid, edge_from, edge_to, edge_weight, last_edge, input ready);
    modport sink (input valid, edge_from, edge_to, edge_weight, last_edge, output ready);
endinterface

interface aoe_res_if;
    logic               valid;
    logic               ready;
    logic        [5:0]  vertex_index;
    logic        [23:0] earliest_time;
    logic signed [24:0] latest_time;
    logic        [1:0]  status;
    logic               last_result;
    modport source (output valid, vertex_index, earliest_time, latest_time, status,
                    last_result, input ready);
    modport sink (input valid, vertex_index, earliest_time, latest_time, status,
                  last_result, output ready);
endinterface

interface aoe_cfg_if;
    logic       valid;
    logic       ready;
    logic       index;
    logic [6:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* src/aoe_ctrl.sv */
// controller state machine of the aoe critical path block
// depends on aoe_pkg
module aoe_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aoe_pkg::t_status  i_status,
    output aoe_pkg::t_cmd     o_cmd
);

    aoe_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= aoe_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            aoe_pkg::ST_IDLE:   if (i_status.last_beat) n_state = aoe_pkg::ST_CLR;
            aoe_pkg::ST_CLR:    if (i_status.clr_last) n_state = aoe_pkg::ST_DEG_A;
            aoe_pkg::ST_DEG_A:  n_state = i_status.k_end ? aoe_pkg::ST_CHK_A : aoe_pkg::ST_DEG_B;
            aoe_pkg::ST_DEG_B:  n_state = aoe_pkg::ST_DEG_C;
            aoe_pkg::ST_DEG_C:  n_state = aoe_pkg::ST_DEG_A;
            aoe_pkg::ST_CHK_A:  n_state = aoe_pkg::ST_CHK_B;
            aoe_pkg::ST_CHK_B:  n_state = i_status.src_bad ? aoe_pkg::ST_ERR : aoe_pkg::ST_FPOP;
            aoe_pkg::ST_FPOP:   n_state = i_status.q_empty ? aoe_pkg::ST_SCAN_A : aoe_pkg::ST_FV;
            aoe_pkg::ST_FV:     n_state = aoe_pkg::ST_FE;
            aoe_pkg::ST_FE:     n_state = aoe_pkg::ST_FA;
            aoe_pkg::ST_FA:     n_state = i_status.k_end ? aoe_pkg::ST_FPOP : aoe_pkg::ST_FB;
            aoe_pkg::ST_FB:     n_state = i_status.match ? aoe_pkg::ST_FC : aoe_pkg::ST_FA;
            aoe_pkg::ST_FC:     n_state = aoe_pkg::ST_FA;
            aoe_pkg::ST_SCAN_A: n_state = i_status.i_end ? aoe_pkg::ST_BPOP : aoe_pkg::ST_SCAN_B;
            aoe_pkg::ST_SCAN_B: n_state = i_status.deg_nz ? aoe_pkg::ST_ERR : aoe_pkg::ST_SCAN_A;
            aoe_pkg::ST_BPOP:   n_state = i_status.top_zero ? aoe_pkg::ST_OUT_A : aoe_pkg::ST_BV;
            aoe_pkg::ST_BV:     n_state = aoe_pkg::ST_BE;
            aoe_pkg::ST_BE:     n_state = aoe_pkg::ST_BA;
            aoe_pkg::ST_BA:     n_state = i_status.k_end ? aoe_pkg::ST_BW : aoe_pkg::ST_BB;
            aoe_pkg::ST_BB:     n_state = i_status.match ? aoe_pkg::ST_BC : aoe_pkg::ST_BA;
            aoe_pkg::ST_BC:     n_state = aoe_pkg::ST_BA;
            aoe_pkg::ST_BW:     n_state = aoe_pkg::ST_BPOP;
            aoe_pkg::ST_OUT_A:  n_state = i_status.i_end ? aoe_pkg::ST_IDLE : aoe_pkg::ST_OUT_B;
            aoe_pkg::ST_OUT_B:  if (i_status.slot_free) n_state = aoe_pkg::ST_OUT_A;
            aoe_pkg::ST_ERR:    if (i_status.slot_free) n_state = aoe_pkg::ST_IDLE;
            default:            n_state = aoe_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            aoe_pkg::ST_IDLE:   o_cmd = aoe_pkg::C_LOAD;
            aoe_pkg::ST_CLR:    o_cmd = aoe_pkg::C_CLR;
            aoe_pkg::ST_DEG_A:  o_cmd = aoe_pkg::C_DEG_A;
            aoe_pkg::ST_DEG_B:  o_cmd = aoe_pkg::C_DEG_B;
            aoe_pkg::ST_DEG_C:  o_cmd = aoe_pkg::C_DEG_C;
            aoe_pkg::ST_CHK_A:  o_cmd = aoe_pkg::C_CHK_A;
            aoe_pkg::ST_CHK_B:  o_cmd = aoe_pkg::C_CHK_B;
            aoe_pkg::ST_FPOP:   o_cmd = aoe_pkg::C_FPOP;
            aoe_pkg::ST_FV:     o_cmd = aoe_pkg::C_FV;
            aoe_pkg::ST_FE:     o_cmd = aoe_pkg::C_FE;
            aoe_pkg::ST_FA:     o_cmd = aoe_pkg::C_FA;
            aoe_pkg::ST_FB:     o_cmd = aoe_pkg::C_FB;
            aoe_pkg::ST_FC:     o_cmd = aoe_pkg::C_FC;
            aoe_pkg::ST_SCAN_A: o_cmd = aoe_pkg::C_SCAN_A;
            aoe_pkg::ST_SCAN_B: o_cmd = aoe_pkg::C_SCAN_B;
            aoe_pkg::ST_BPOP:   o_cmd = aoe_pkg::C_BPOP;
            aoe_pkg::ST_BV:     o_cmd = aoe_pkg::C_BV;
            aoe_pkg::ST_BE:     o_cmd = aoe_pkg::C_BE;
            aoe_pkg::ST_BA:     o_cmd = aoe_pkg::C_BA;
            aoe_pkg::ST_BB:     o_cmd = aoe_pkg::C_BB;
            aoe_pkg::ST_BC:     o_cmd = aoe_pkg::C_BC;
            aoe_pkg::ST_BW:     o_cmd = aoe_pkg::C_BW;
            aoe_pkg::ST_OUT_A:  o_cmd = aoe_pkg::C_OUT_A;
            aoe_pkg::ST_OUT_B:  o_cmd = aoe_pkg::C_OUT_B;
            aoe_pkg::ST_ERR:    o_cmd = aoe_pkg::C_ERR;
            default:            o_cmd = aoe_pkg::C_LOAD;
        endcase
    end

endmodule

/* src/aoe_dpath.sv */
// datapath of the aoe critical path block: edge and vertex memories, counters, output register
// depends on aoe_pkg and aoe_if
module aoe_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aoe_pkg::t_cmd     i_cmd,
    output aoe_pkg::t_status  o_status,
    aoe_edge_if.sink          i_edge,
    aoe_res_if.source         o_res,
    aoe_cfg_if.sink           i_cfg
);

    // config
    logic [6:0] r_vcount;
    logic [5:0] r_src;
    logic [6:0] w_n;

    // edge store
    logic [5:0]  m_tail [aoe_pkg::MaxEdges];
    logic [5:0]  m_head [aoe_pkg::MaxEdges];
    logic [15:0] m_wt   [aoe_pkg::MaxEdges];
    logic [5:0]  r_et, r_eh;
    logic [15:0] r_ew;

    // vertex stores
    logic        [7:0]  m_deg  [aoe_pkg::MaxVertices];
    logic        [23:0] m_earl [aoe_pkg::MaxVertices];
    logic signed [24:0] m_late [aoe_pkg::MaxVertices];
    logic        [5:0]  m_stk  [aoe_pkg::MaxVertices];
    logic        [7:0]  r_dg;
    logic        [23:0] r_er;
    logic signed [24:0] r_lt;
    logic        [5:0]  r_sk;
    logic        [5:0]  w_va;

    logic [7:0]  r_ecount, r_k;
    logic [6:0]  r_i, r_top, r_done;
    logic [5:0]  r_v;
    logic [23:0] r_ev, r_best;
    logic        r_any;
    logic [1:0]  r_err;
    logic [6:0]  w_topm1;
    logic        w_accept, w_match, w_slot_free;
    logic [24:0] w_sum;
    logic [23:0] w_t;
    logic signed [25:0] w_d;
    logic [23:0] w_dc;

    // output register
    logic               r_ov;
    logic        [5:0]  r_oidx;
    logic        [23:0] r_oe;
    logic signed [24:0] r_ol;
    logic        [1:0]  r_ost;
    logic               r_olast;
    logic               w_load;

    assign i_cfg.ready = 1'b1;
    assign i_edge.ready = (i_cmd == aoe_pkg::C_LOAD);
    assign w_accept = i_edge.valid && i_edge.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= 7'd64;
            r_src    <= 6'd0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                aoe_pkg::CfgVertexCount:  r_vcount <= i_cfg.data;
                aoe_pkg::CfgSourceVertex: r_src    <= i_cfg.data[5:0];
                default: ;
            endcase
        end
    end

    assign w_n = (r_vcount == 7'd0) ? 7'd1 :
                 (r_vcount > 7'(aoe_pkg::MaxVertices)) ? 7'(aoe_pkg::MaxVertices) : r_vcount;

    assign w_match = (r_et == r_v) && ({1'b0, r_eh} < w_n);
    assign w_topm1 = r_top - 7'd1;
    assign w_slot_free = !r_ov || o_res.ready;

    // saturating forward sum and clamped backward difference
    assign w_sum = {1'b0, r_ev} + {9'd0, r_ew};
    assign w_t   = w_sum[24] ? 24'hFFFFFF : w_sum[23:0];
    assign w_d   = 26'(r_lt) - $signed({10'd0, r_ew});
    assign w_dc  = w_d[25] ? 24'd0 : w_d[23:0];

    always_comb begin
        case (i_cmd)
            aoe_pkg::C_DEG_B, aoe_pkg::C_FB, aoe_pkg::C_BB: w_va = r_eh;
            aoe_pkg::C_CHK_A:                                w_va = r_src;
            aoe_pkg::C_FPOP:                                 w_va = r_done[5:0];
            aoe_pkg::C_FV, aoe_pkg::C_BV:                    w_va = r_sk;
            aoe_pkg::C_SCAN_A, aoe_pkg::C_OUT_A, aoe_pkg::C_OUT_B: w_va = r_i[5:0];
            aoe_pkg::C_BPOP:                                 w_va = w_topm1[5:0];
            default:                                         w_va = r_v;
        endcase
    end

    // edge memories
    always_ff @(posedge i_clk) begin
        if (w_accept && (r_ecount < 8'(aoe_pkg::MaxEdges))) begin
            m_tail[r_ecount[6:0]] <= i_edge.edge_from;
            m_head[r_ecount[6:0]] <= i_edge.edge_to;
            m_wt[r_ecount[6:0]]   <= i_edge.edge_weight;
        end
        r_et <= m_tail[r_k[6:0]];
        r_eh <= m_head[r_k[6:0]];
        r_ew <= m_wt[r_k[6:0]];
    end

    // vertex memories
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            aoe_pkg::C_CLR: begin
                m_deg[r_i[5:0]]  <= 8'd0;
                m_earl[r_i[5:0]] <= 24'd0;
                m_late[r_i[5:0]] <= -25'sd1;
            end
            aoe_pkg::C_DEG_C: begin
                if (({1'b0, r_et} < w_n) && ({1'b0, r_eh} < w_n)) begin
                    m_deg[r_eh] <= r_dg + 8'd1;
                end
            end
            aoe_pkg::C_CHK_B: m_stk[0] <= r_src;
            aoe_pkg::C_FC: begin
                if (r_dg != 8'd0) begin
                    m_deg[r_eh] <= r_dg - 8'd1;
                    if (w_t > r_er) begin
                        m_earl[r_eh] <= w_t;
                    end
                    if (r_dg == 8'd1 && r_top < 7'(aoe_pkg::MaxVertices)) begin
                        m_stk[r_top[5:0]] <= r_eh;
                    end
                end
            end
            aoe_pkg::C_BW: m_late[r_v] <= r_any ? $signed({1'b0, r_best}) : $signed({1'b0, r_ev});
            default: ;
        endcase
        r_dg <= m_deg[w_va];
        r_er <= m_earl[w_va];
        r_lt <= m_late[w_va];
        r_sk <= m_stk[w_va];
    end

    // counters and working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ecount <= 8'd0;
            r_k      <= 8'd0;
            r_i      <= 7'd0;
            r_top    <= 7'd0;
            r_done   <= 7'd0;
            r_err    <= aoe_pkg::StatusOk;
        end else begin
            case (i_cmd)
                aoe_pkg::C_LOAD: begin
                    r_i <= 7'd0;
                    if (w_accept && (r_ecount < 8'(aoe_pkg::MaxEdges))) begin
                        r_ecount <= r_ecount + 8'd1;
                    end
                end
                aoe_pkg::C_CLR: begin
                    r_i <= r_i + 7'd1;
                    r_k <= 8'd0;
                end
                aoe_pkg::C_DEG_C: r_k <= r_k + 8'd1;
                aoe_pkg::C_CHK_B: begin
                    r_top  <= 7'd1;
                    r_done <= 7'd0;
                    r_err  <= aoe_pkg::StatusBadSrc;
                end
                aoe_pkg::C_FPOP: begin
                    r_i <= 7'd0;
                    if (r_done != r_top) r_done <= r_done + 7'd1;
                end
                aoe_pkg::C_FV, aoe_pkg::C_BV: r_v <= r_sk;
                aoe_pkg::C_FE: begin
                    r_ev <= r_er;
                    r_k  <= 8'd0;
                end
                aoe_pkg::C_FB, aoe_pkg::C_BB: if (!w_match) r_k <= r_k + 8'd1;
                aoe_pkg::C_FC: begin
                    r_k <= r_k + 8'd1;
                    if (r_dg == 8'd1 && r_top < 7'(aoe_pkg::MaxVertices)) begin
                        r_top <= r_top + 7'd1;
                    end
                end
                aoe_pkg::C_SCAN_B: begin
                    r_i   <= r_i + 7'd1;
                    r_err <= aoe_pkg::StatusNotDag;
                end
                aoe_pkg::C_BPOP: begin
                    r_i <= 7'd0;
                    if (r_top != 7'd0) r_top <= w_topm1;
                end
                aoe_pkg::C_BE: begin
                    r_ev   <= r_er;
                    r_k    <= 8'd0;
                    r_any  <= 1'b0;
                    r_best <= 24'd0;
                end
                aoe_pkg::C_BC: begin
                    r_k   <= r_k + 8'd1;
                    r_any <= 1'b1;
                    if (!r_any || w_dc < r_best) r_best <= w_dc;
                end
                aoe_pkg::C_OUT_A: if (r_i == w_n) r_ecount <= 8'd0;
                aoe_pkg::C_OUT_B: if (w_slot_free) r_i <= r_i + 7'd1;
                aoe_pkg::C_ERR:   if (w_slot_free) r_ecount <= 8'd0;
                default: ;
            endcase
        end
    end

    assign w_load = w_slot_free && ((i_cmd == aoe_pkg::C_OUT_B) || (i_cmd == aoe_pkg::C_ERR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_res.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            if (i_cmd == aoe_pkg::C_ERR) begin
                r_oidx  <= 6'd0;
                r_oe    <= 24'd0;
                r_ol    <= 25'sd0;
                r_ost   <= r_err;
                r_olast <= 1'b1;
            end else begin
                r_oidx  <= r_i[5:0];
                r_oe    <= r_er;
                r_ol    <= r_lt;
                r_ost   <= aoe_pkg::StatusOk;
                r_olast <= (r_i + 7'd1 == w_n);
            end
        end
    end

    assign o_res.valid         = r_ov;
    assign o_res.vertex_index  = r_oidx;
    assign o_res.earliest_time = r_oe;
    assign o_res.latest_time   = r_ol;
    assign o_res.status        = r_ost;
    assign o_res.last_result   = r_olast;

    always_comb begin
        o_status.last_beat = w_accept && i_edge.last_edge;
        o_status.clr_last  = (r_i == 7'(aoe_pkg::MaxVertices - 1));
        o_status.k_end     = (r_k == r_ecount);
        o_status.match     = w_match;
        o_status.src_bad   = ({1'b0, r_src} >= w_n) || (r_dg != 8'd0);
        o_status.q_empty   = (r_done == r_top);
        o_status.i_end     = (r_i == w_n);
        o_status.deg_nz    = (r_dg != 8'd0);
        o_status.top_zero  = (r_top == 7'd0);
        o_status.slot_free = w_slot_free;
    end

endmodule

/* src/aoe_critical_path_times_top.sv */
// top level of the aoe critical path block: controller plus datapath
// depends on aoe_pkg, aoe_if, aoe_ctrl and aoe_dpath
//
// usage:
//   i_edge carries one activity edge per beat; last_edge closes the network.
//   edges load at one per cycle while idle into a 128-entry table; further edges are dropped.
//   i_cfg writes vertex_count (index 0) or source_vertex (index 1), always ready,
//   and must only be written while the block is idle.
//   o_res returns one beat per vertex in index order (last_result on the final
//   one), or a single error beat with status bad source or not a dag.
// sequence:
//   after the last edge: a clear sweep of all 64 vertex entries, degree counting
//   over the stored edges, the source check, then per reached vertex a forward
//   walk of the stored edges, a scan of every vertex, then per reached vertex a
//   backward walk of the stored edges, then the result beats. the edge table
//   has one read port, so each pass walks all stored edges. no edge is accepted
//   until the last result beat sits in the output register.
// reset: synchronous active low; clears counters and state, config goes to
//   64 vertices and source 0.
// stall: o_res holds its beat while ready is low and the result walk pauses.
module aoe_critical_path_times_top (
    input logic        i_clk,
    input logic        i_rst_n,
    aoe_edge_if.sink   i_edge,
    aoe_res_if.source  o_res,
    aoe_cfg_if.sink    i_cfg
);

    aoe_pkg::t_cmd    w_cmd;
    aoe_pkg::t_status w_status;

    aoe_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    aoe_dpath u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .i_edge   (i_edge),
        .o_res    (o_res),
        .i_cfg    (i_cfg)
    );

endmodule
